@@ hdl/sdrr_pkg.sv @@
package sdrr_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int QUEUE_DEPTH       = 4;

	localparam int DATA_BITS = 32;
	localparam int FRAC_BITS = 32;
	localparam int MSB_BITS  = 5;
	localparam int LOG_BITS  = 24;
	localparam int ROM_BITS  = 16;
	localparam int INV_BITS  = 24;

	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [31:0] LN2_Q24 = 32'd11629080;
	localparam logic [INV_BITS-1:0] INV_TE_RESET = 24'd2185;

	typedef enum logic [1:0] {
		CFG_CONVERT_ENABLE = 2'd0,
		CFG_INV_ECHO_TIME  = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic                 pos;
		logic                 first;
		logic [DATA_BITS-1:0] sample;
		logic [MSB_BITS-1:0]  msb;
	} meta_t;

	typedef struct packed {
		meta_t                meta;
		logic [FRAC_BITS-1:0] frac;
	} item_t;

	// ln(1 + i/N) in q0.16 from y0 = ((N + i) << 30) / N, log2 by repeated squaring
	function automatic logic [ROM_BITS-1:0] ln_rom_entry(input logic [63:0] y0);
		logic [63:0] y;
		logic [63:0] l2;
		logic [63:0] prod;
		y  = y0;
		l2 = '0;
		if (y >= 64'h8000_0000) begin
			l2 = 64'd1 << 24;
		end else begin
			for (int b = 0; b < 24; b++) begin
				y  = (y * y) >> 30;
				l2 = l2 << 1;
				if (y >= 64'h8000_0000) begin
					l2 = l2 | 64'd1;
					y  = y >> 1;
				end
			end
		end
		prod = l2 * 64'(LN2_Q24) + (64'd1 << 31);
		return ROM_BITS'(prod >> 32);
	endfunction

endpackage

@@ hdl/signal_to_delta_relaxation_rate_unit.sv @@
// channel   direction  tdata (low bit up)                 tuser
// s_*       in         sample, zero padded to bytes        first_of_voxel
// m_*       out        rate_value (q16.16)                 forced_zero
// cfg_*     in         write only: 0 convert_enable, 1 inv_echo_time
//
// sustains one transaction per cycle while the output is not stalled; a result
// passes the front register, the queue and the seven back stages (log table,
// multipliers, rounding)
// the baseline is held in a register updated in one back stage, so the next
// voxel sample sees it without a bubble
// reset is asynchronous and needs no clearing pass
// a stalled output freezes the back stages; the queue and front keep taking input until the queue is full
module signal_to_delta_relaxation_rate_unit #(
	parameter int SAMPLE_BITS       = sdrr_pkg::SAMPLE_BITS,
	parameter int LOG_TABLE_ENTRIES = sdrr_pkg::LOG_TABLE_ENTRIES,
	parameter int QUEUE_DEPTH       = sdrr_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
	input  logic                                s_tuser,   // first_of_voxel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sdrr_pkg::DATA_BITS-1:0]      m_tdata,   // rate_value
	output logic                                m_tuser,   // forced_zero
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [sdrr_pkg::INV_BITS-1:0]       cfg_data
);

	logic                          convert_enable_q;
	logic [sdrr_pkg::INV_BITS-1:0] inv_echo_time_q;
	logic                          push_valid;
	logic                          push_ready;
	sdrr_pkg::item_t               push_item;
	logic                          pop_valid;
	logic                          pop_ready;
	sdrr_pkg::item_t               pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			convert_enable_q <= 1'b0;
			inv_echo_time_q  <= sdrr_pkg::INV_TE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdrr_pkg::CFG_CONVERT_ENABLE: convert_enable_q <= cfg_data[0];
				sdrr_pkg::CFG_INV_ECHO_TIME:  inv_echo_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	sdrr_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.sample        (s_tdata[SAMPLE_BITS-1:0]),
		.first_of_voxel(s_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	sdrr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	sdrr_back #(
		.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (pop_valid),
		.q_pop         (pop_ready),
		.q_item        (pop_item),
		.convert_enable(convert_enable_q),
		.inv_echo_time (inv_echo_time_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.rate_value    (m_tdata),
		.forced_zero   (m_tuser)
	);

endmodule

@@ hdl/sdrr_front.sv @@
module sdrr_front #(
	parameter int SAMPLE_BITS = sdrr_pkg::SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   first_of_voxel,
	output logic                   push_valid,
	input  logic                   push_ready,
	output sdrr_pkg::item_t        push_item
);

	localparam int EW = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

	logic signed [SAMPLE_BITS-1:0] smp;
	logic                          pos;
	logic [sdrr_pkg::MSB_BITS-1:0] msb;
	logic [SAMPLE_BITS-1:0]        x_low;
	logic [63:0]                   shifted;
	sdrr_pkg::item_t               item_d;
	sdrr_pkg::item_t               item_s1;
	logic                          valid_s1;

	assign smp = sample;
	assign pos = !smp[SAMPLE_BITS-1] && (smp != '0);

	// top set bit of the positive sample
	always_comb begin
		msb = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (smp[i]) begin
				msb = sdrr_pkg::MSB_BITS'(i);
			end
		end
	end

	always_comb begin
		x_low                = smp;
		x_low[msb[EW-1:0]]   = 1'b0;
		shifted              = {32'(x_low), 32'd0} >> msb;
	end

	always_comb begin
		item_d.meta.pos    = pos;
		item_d.meta.first  = first_of_voxel;
		item_d.meta.sample = sdrr_pkg::DATA_BITS'(smp);
		item_d.meta.msb    = pos ? msb : '0;
		item_d.frac        = pos ? shifted[sdrr_pkg::FRAC_BITS-1:0] : '0;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	held_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !push_ready |=> valid_s1 && $stable(item_s1))
		else $error("front stage lost its item while the queue was full");

endmodule

@@ hdl/sdrr_queue.sv @@
module sdrr_queue #(
	parameter int DEPTH = sdrr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sdrr_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sdrr_pkg::item_t pop_item
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	sdrr_pkg::item_t       mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != CNT_BITS'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("queue count overflow");

endmodule

@@ hdl/sdrr_back.sv @@
module sdrr_back #(
	parameter int LOG_TABLE_ENTRIES = sdrr_pkg::LOG_TABLE_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  sdrr_pkg::item_t               q_item,
	input  logic                          convert_enable,
	input  logic [sdrr_pkg::INV_BITS-1:0] inv_echo_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdrr_pkg::DATA_BITS-1:0] rate_value,
	output logic                          forced_zero
);

	localparam int NW       = $clog2(LOG_TABLE_ENTRIES + 1);
	localparam int IDX_BITS = $clog2(LOG_TABLE_ENTRIES);
	localparam int PW       = sdrr_pkg::FRAC_BITS + NW;
	localparam int RB       = sdrr_pkg::ROM_BITS;
	localparam int LB       = sdrr_pkg::LOG_BITS;
	localparam int PRODW    = LB + sdrr_pkg::INV_BITS;

	logic [RB-1:0] ln_rom [0:LOG_TABLE_ENTRIES];

	for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
		localparam logic [63:0] Y0 =
			((64'(LOG_TABLE_ENTRIES) + 64'(g)) << 30) / LOG_TABLE_ENTRIES;
		assign ln_rom[g] = sdrr_pkg::ln_rom_entry(Y0);
	end

	logic adv;

	logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	sdrr_pkg::meta_t            meta_s1, meta_s2, meta_s3, meta_s4;
	logic [PW-1:0]              p_s1;
	logic [RB-1:0]              lo_s2, hi_s2, lo_s3, interp_s3;
	logic [sdrr_pkg::FRAC_BITS-1:0] r_s2;
	logic [LB-1:0]              slog_s4;
	logic [sdrr_pkg::DATA_BITS-1:0] sample_s5, sample_s6;
	logic                       forced_s5, forced_s6, dneg_s5, dneg_s6;
	logic [LB-1:0]              dmag_s5;
	logic [PRODW-1:0]           prod_s6;

	logic [LB-1:0]              base_log_q;
	logic                       base_pos_q;
	logic                       out_valid_q;
	logic [sdrr_pkg::DATA_BITS-1:0] rate_q;
	logic                       forced_q;

	logic [IDX_BITS:0]          idx_lo, idx_hi;
	logic [RB-1:0]              diff_s2;
	logic [47:0]                interp_prod;
	logic [LB-1:0]              slog_d;
	logic [LB-1:0]              base_eff;
	logic                       bpos_eff;
	logic [PRODW:0]             rounded;
	logic [32:0]                qmag;
	logic [sdrr_pkg::DATA_BITS-1:0] rate_d;
	logic                       forced_d;

	assign adv       = !out_valid_q || out_ready;
	assign q_pop     = adv && q_valid;
	assign out_valid = out_valid_q;
	assign rate_value  = rate_q;
	assign forced_zero = forced_q;

	// table lookup and interpolation
	assign idx_lo      = {1'b0, p_s1[sdrr_pkg::FRAC_BITS +: IDX_BITS]};
	assign idx_hi      = idx_lo + 1'b1;
	assign diff_s2     = (hi_s2 >= lo_s2) ? hi_s2 - lo_s2 : '0;
	assign interp_prod = 48'(diff_s2) * 48'(r_s2);
	assign slog_d      = meta_s3.pos ?
		LB'(LB'(meta_s3.msb) * LB'(sdrr_pkg::LN2_Q16) + LB'(lo_s3) + LB'(interp_s3)) : '0;

	// baseline of this item, the item itself when it opens a voxel
	assign base_eff = meta_s4.first ? slog_s4 : base_log_q;
	assign bpos_eff = meta_s4.first ? meta_s4.pos : base_pos_q;

	always_comb begin
		rounded = (PRODW + 1)'(prod_s6) + (PRODW + 1)'(16'h8000);
		qmag    = 33'(rounded >> 16);
		if (!convert_enable) begin
			rate_d   = sample_s6;
			forced_d = 1'b0;
		end else if (forced_s6) begin
			rate_d   = '0;
			forced_d = 1'b1;
		end else if (dneg_s6) begin
			if (qmag > 33'h0_8000_0000) begin
				qmag = 33'h0_8000_0000;
			end
			rate_d   = sdrr_pkg::DATA_BITS'(-qmag);
			forced_d = 1'b0;
		end else begin
			if (qmag > 33'h0_7FFF_FFFF) begin
				qmag = 33'h0_7FFF_FFFF;
			end
			rate_d   = sdrr_pkg::DATA_BITS'(qmag);
			forced_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
			base_log_q  <= '0;
			base_pos_q  <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
			if (v_s4 && meta_s4.first) begin
				base_log_q <= slog_s4;
				base_pos_q <= meta_s4.pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1   <= q_item.meta;
			p_s1      <= PW'(q_item.frac) * PW'(LOG_TABLE_ENTRIES);

			meta_s2   <= meta_s1;
			lo_s2     <= ln_rom[idx_lo];
			hi_s2     <= ln_rom[idx_hi];
			r_s2      <= p_s1[sdrr_pkg::FRAC_BITS-1:0];

			meta_s3   <= meta_s2;
			lo_s3     <= lo_s2;
			interp_s3 <= interp_prod[47:32];

			meta_s4   <= meta_s3;
			slog_s4   <= slog_d;

			sample_s5 <= meta_s4.sample;
			forced_s5 <= !bpos_eff || !meta_s4.pos;
			dneg_s5   <= slog_s4 > base_eff;
			dmag_s5   <= (slog_s4 > base_eff) ? slog_s4 - base_eff : base_eff - slog_s4;

			sample_s6 <= sample_s5;
			forced_s6 <= forced_s5;
			dneg_s6   <= dneg_s5;
			prod_s6   <= PRODW'(dmag_s5) * PRODW'(inv_echo_time);

			rate_q    <= rate_d;
			forced_q  <= forced_d;
		end
	end

	forced_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && forced_q |-> rate_q == '0)
		else $error("forced result carries a nonzero rate");

	no_log_without_baseline: assert property (@(posedge clk) disable iff (!arst_n)
		!base_pos_q |-> base_log_q == '0)
		else $error("baseline log set for a non-positive baseline");

	stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(rate_q) && $stable(forced_q))
		else $error("result changed while stalled");

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW  = sdrr_pkg::SAMPLE_BITS;
	localparam int TDW = ((SW + 7) / 8) * 8;
	localparam int NT  = sdrr_pkg::LOG_TABLE_ENTRIES;
	localparam int NTW = $clog2(NT + 1);
	localparam int IW  = sdrr_pkg::INV_BITS;
	localparam int LW  = sdrr_pkg::LOG_BITS;
	localparam int DW  = sdrr_pkg::DATA_BITS;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 138;

	// indexes past the register list, written to check they are ignored
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [1:0]          idx;
		logic [IW-1:0]       val;
		logic [SW-1:0]       smp;
		logic                fst;
		logic                typed;
		logic [31:0]         rate;
		logic                zero;
	} plan_row_t;

	typedef struct packed {
		logic [31:0] rate;
		logic        zero;
	} rate_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDW-1:0]       s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DW-1:0]        m_tdata;
	logic                 m_tuser;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [IW-1:0]        cfg_data = '0;

	signal_to_delta_relaxation_rate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	logic [15:0]         ln_table [0:NT];
	logic                conv_en;
	logic [IW-1:0]       inv_te;
	logic [LW-1:0]       voxel_base_log;
	logic                voxel_base_pos;

	rate_result_t pending_rates [$];
	plan_row_t    plan [$];

	int  errors = 0;
	int  rates_checked = 0;
	int  samples_sent = 0;
	int  writes_done = 0;
	bit  sender_idles = 1'b0;
	bit  sink_stalls = 1'b0;
	bit  quiet = 1'b0;
	int  stall_left = 0;

	function automatic logic [15:0] table_entry(input int i);
		logic [63:0] y;
		logic [63:0] l2;
		logic [63:0] prod;
		y  = ((64'(NT) + 64'(i)) << 30) / 64'(NT);
		l2 = '0;
		if (y >= 64'h8000_0000) begin
			l2 = 64'd1 << 24;
		end else begin
			for (int b = 0; b < 24; b++) begin
				y  = (y * y) >> 30;
				l2 = l2 << 1;
				if (y >= 64'h8000_0000) begin
					l2 = l2 | 64'd1;
					y  = y >> 1;
				end
			end
		end
		prod = l2 * 64'(sdrr_pkg::LN2_Q24) + (64'd1 << 31);
		return 16'(prod >> 32);
	endfunction

	// q8.16 natural log of a positive sample, table plus linear interpolation
	function automatic logic [LW-1:0] ln_fixed(input logic [SW-1:0] x);
		logic [63:0] xv;
		logic [63:0] f;
		logic [63:0] p;
		logic [63:0] idx;
		logic [63:0] r;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] interp;
		int          e;
		xv = 64'(x);
		e  = 0;
		for (int b = 0; b < SW; b++)
			if (xv[b])
				e = b;
		f   = ((xv - (64'd1 << e)) << 32) >> e;
		p   = f * 64'(NT);
		idx = p >> 32;
		if (idx >= 64'(NT))
			idx = 64'(NT - 1);
		r      = p & 64'hFFFF_FFFF;
		lo     = 64'(ln_table[NTW'(idx)]);
		hi     = 64'(ln_table[NTW'(idx + 64'd1)]);
		interp = (hi >= lo) ? (((hi - lo) * r) >> 32) : 64'd0;
		return LW'(64'(e) * 64'(sdrr_pkg::LN2_Q16) + lo + interp);
	endfunction

	function automatic rate_result_t predict_rate(input logic [SW-1:0] smp, input logic fst);
		rate_result_t        res;
		logic                pos;
		logic                dneg;
		logic [LW-1:0]       slog;
		logic [LW-1:0]       dmag;
		logic [63:0]         q;
		pos  = !smp[SW-1] && (smp != '0);
		slog = pos ? ln_fixed(smp) : '0;
		if (fst) begin
			voxel_base_pos = pos;
			voxel_base_log = slog;
		end
		if (!conv_en) begin
			res.rate = 32'($signed(smp));
			res.zero = 1'b0;
		end else if (!voxel_base_pos || !pos) begin
			res.rate = '0;
			res.zero = 1'b1;
		end else begin
			dneg = slog > voxel_base_log;
			dmag = dneg ? slog - voxel_base_log : voxel_base_log - slog;
			q    = (64'(dmag) * 64'(inv_te) + 64'h8000) >> 16;
			if (dneg) begin
				if (q > 64'h8000_0000)
					q = 64'h8000_0000;
				res.rate = 32'(64'd0 - q);
			end else begin
				if (q > 64'h7FFF_FFFF)
					q = 64'h7FFF_FFFF;
				res.rate = q[31:0];
			end
			res.zero = 1'b0;
		end
		return res;
	endfunction

	task automatic add_sample(input logic [SW-1:0] smp, input logic fst);
		plan.push_back('{ROW_SAMPLE, 2'd0, '0, smp, fst, 1'b0, 32'd0, 1'b0});
	endtask

	task automatic add_typed(input logic [SW-1:0] smp, input logic fst,
			input logic [31:0] rate, input logic zero);
		plan.push_back('{ROW_SAMPLE, 2'd0, '0, smp, fst, 1'b1, rate, zero});
	endtask

	task automatic add_write(input logic [1:0] idx, input logic [IW-1:0] val);
		plan.push_back('{ROW_WRITE, idx, val, '0, 1'b0, 1'b0, 32'd0, 1'b0});
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		while (pending_rates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [IW-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sdrr_pkg::CFG_CONVERT_ENABLE)
			conv_en = val[0];
		else if (idx == sdrr_pkg::CFG_INV_ECHO_TIME)
			inv_te = val;
		writes_done++;
		@(posedge clk);
	endtask

	task automatic push_sample(input logic [SW-1:0] smp, input logic fst,
			input logic typed, input logic [31:0] rate, input logic zero);
		rate_result_t res;
		if (sender_idles && !quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDW'(smp);
		s_tuser  <= fst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = predict_rate(smp, fst);
		if (typed) begin
			res.rate = rate;
			res.zero = zero;
		end
		pending_rates.push_back(res);
		samples_sent++;
	endtask

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return SW'(1);
			1:       return {1'b0, {(SW-1){1'b1}}};
			2:       return '0;
			3:       return {1'b1, (SW-1)'($urandom)};
			4:       return SW'($urandom);
			5, 6, 7: return SW'($urandom_range(1, 255));
			default: return SW'($urandom_range(1, (1 << (SW - 1)) - 1));
		endcase
	endfunction

	// output side: random stall bursts on m_tready
	always @(posedge clk) begin
		if (quiet || !sink_stalls) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker: one transaction against the oldest expectation
	always @(posedge clk) begin
		rate_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rates.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual rate %h zero %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_rates.pop_front();
				rates_checked++;
				if (m_tdata !== want.rate) begin
					errors++;
					$display("%0t: rate_value mismatch, expected %h, actual %h",
						$time, want.rate, m_tdata);
				end
				if (m_tuser !== want.zero) begin
					errors++;
					$display("%0t: forced_zero mismatch, expected %b, actual %b",
						$time, want.zero, m_tuser);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int sent;
		int run;
		bit pressed;
		for (int i = 0; i <= NT; i++)
			ln_table[NTW'(i)] = table_entry(i);
		conv_en        = 1'b0;
		inv_te         = sdrr_pkg::INV_TE_RESET;
		voxel_base_log = '0;
		voxel_base_pos = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: pass-through, then enabled with no baseline yet
		add_typed(16'h1234, 1'b0, 32'h0000_1234, 1'b0);
		add_write(sdrr_pkg::CFG_CONVERT_ENABLE, 24'h000001);
		add_typed(16'h0100, 1'b0, 32'h0000_0000, 1'b1);
		// baseline captured while disabled, upper data bits masked
		add_write(sdrr_pkg::CFG_CONVERT_ENABLE, 24'hFFFFFE);
		add_typed(16'h7FFF, 1'b1, 32'h0000_7FFF, 1'b0);
		add_typed(16'h8000, 1'b0, 32'hFFFF_8000, 1'b0);
		add_typed(16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
		add_typed(16'h0000, 1'b0, 32'h0000_0000, 1'b0);
		add_write(CFG_SPARE_LO, 24'h000000);
		add_write(CFG_SPARE_HI, 24'hFFFFFF);
		add_write(sdrr_pkg::CFG_CONVERT_ENABLE, 24'hFFFFFF);
		add_typed(16'h7FFF, 1'b0, 32'h0000_0000, 1'b0);
		add_sample(16'h0001, 1'b0);
		add_typed(16'h8000, 1'b0, 32'h0000_0000, 1'b1);
		add_typed(16'h0000, 1'b0, 32'h0000_0000, 1'b1);
		add_typed(16'h0001, 1'b1, 32'h0000_0000, 1'b0);
		add_sample(16'h7FFF, 1'b0);
		add_write(sdrr_pkg::CFG_INV_ECHO_TIME, 24'hFFFFFF);
		add_sample(16'h7FFF, 1'b0);
		add_typed(16'h0001, 1'b0, 32'h0000_0000, 1'b0);
		// non-positive baselines force zero
		add_typed(16'hFFFF, 1'b1, 32'h0000_0000, 1'b1);
		add_typed(16'h0005, 1'b0, 32'h0000_0000, 1'b1);
		add_typed(16'h0000, 1'b1, 32'h0000_0000, 1'b1);
		add_write(sdrr_pkg::CFG_INV_ECHO_TIME, 24'h000001);
		add_typed(16'h4000, 1'b1, 32'h0000_0000, 1'b0);
		add_sample(16'h0002, 1'b0);
		add_write(sdrr_pkg::CFG_INV_ECHO_TIME, 24'h000000);
		add_typed(16'h0003, 1'b0, 32'h0000_0000, 1'b0);
		add_write(sdrr_pkg::CFG_INV_ECHO_TIME, sdrr_pkg::INV_TE_RESET);
		add_sample(16'h0003, 1'b0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].idx, plan[i].val);
			else
				push_sample(plan[i].smp, plan[i].fst, plan[i].typed, plan[i].rate,
					plan[i].zero);
		end

		pressed = 1'b0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			sender_idles = $urandom_range(0, 3) != 0;
			sink_stalls  = $urandom_range(0, 3) != 0;
			quiet        = (ph == RANDOM_PHASES - 1);
			write_reg(sdrr_pkg::CFG_CONVERT_ENABLE,
				{(IW - 1)'($urandom), (ph != 0) && ($urandom_range(0, 3) != 0)});
			case (ph)
				1, 6:    write_reg(sdrr_pkg::CFG_INV_ECHO_TIME, 24'hFFFFFF);
				2:       write_reg(sdrr_pkg::CFG_INV_ECHO_TIME, 24'h000001);
				3:       write_reg(sdrr_pkg::CFG_INV_ECHO_TIME, sdrr_pkg::INV_TE_RESET);
				4:       write_reg(sdrr_pkg::CFG_INV_ECHO_TIME,
						IW'($urandom_range(1, 4095)));
				default: write_reg(sdrr_pkg::CFG_INV_ECHO_TIME,
						IW'($urandom_range(1, 24'hFFFFFF)));
			endcase
			if (ph == 3)
				write_reg(CFG_SPARE_LO, IW'($urandom));
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if (ph == 4 && !pressed && sent >= ITEMS_PER_PHASE / 2) begin
					drain_results();
					pressed = 1'b1;
				end
				if ($urandom_range(0, 9) == 0) begin
					push_sample(SW'($urandom), 1'($urandom), 1'b0, 32'd0, 1'b0);
					sent++;
				end else begin
					push_sample(pick_sample(), 1'b1, 1'b0, 32'd0, 1'b0);
					sent++;
					run = $urandom_range(1, 20);
					for (int k = 0; k < run; k++) begin
						push_sample(pick_sample(), 1'b0, 1'b0, 32'd0, 1'b0);
						sent++;
					end
				end
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("ran %0d samples through %0d register writes, %0d results checked",
			samples_sent, writes_done, rates_checked);
		$display("covered pass-through, forced zero, extreme echo times and voxel runs");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sdrr_pkg.sv
hdl/sdrr_front.sv
hdl/sdrr_queue.sv
hdl/sdrr_back.sv
hdl/signal_to_delta_relaxation_rate_unit.sv
tb/testbench.sv
